[src/bilinear_rgba_sampler_assert.svh]
`ifndef BILINEAR_RGBA_SAMPLER_ASSERT_SVH
`define BILINEAR_RGBA_SAMPLER_ASSERT_SVH

// Expects clk_i and rst_ni in the enclosing scope.
`define BRS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

`define BRS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

[src/brs_pkg.sv]
package brs_pkg;

  localparam int unsigned DIM_W     = 9;
  localparam int unsigned COORD_W   = 8;
  localparam int unsigned FRAC_W    = 8;
  localparam int unsigned PIX_W     = 32;
  localparam int unsigned CH_W      = 8;
  localparam int unsigned NUM_CH    = 4;
  localparam int unsigned NUM_TAP   = 4;
  localparam int unsigned WT_W      = 9;
  localparam int unsigned PROD_W    = CH_W + WT_W;
  localparam int unsigned SUM_W     = PROD_W + 2;
  localparam int unsigned LIN_W     = COORD_W + DIM_W + 1;
  localparam int unsigned S_DATA_W  = 80;
  localparam int unsigned M_DATA_W  = 32;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  localparam logic [DIM_W-1:0] DIM_MIN   = 9'd2;
  localparam logic [DIM_W-1:0] DIM_RESET = 9'd256;
  localparam logic [WT_W-1:0]  FULL_WT   = 9'd256;

  typedef logic [NUM_TAP-1:0][WT_W-1:0]  wt_vec_t;
  typedef logic [NUM_TAP-1:0][PIX_W-1:0] tap_vec_t;

  typedef struct packed {
    logic             s1;
    logic             s2;
    logic             s3;
    logic             s4;
  } pipe_en_t;

  typedef struct packed {
    logic             smp;
    logic             wr;
    logic             oor;
    logic [LIN_W-1:0] a0;
    logic [DIM_W-1:0] w;
    logic [PIX_W-1:0] pix;
    wt_vec_t          wt;
  } addr_pl_t;

  typedef struct packed {
    logic     oor;
    tap_vec_t tap;
    wt_vec_t  wt;
  } tap_pl_t;

endpackage

[src/brs_addr.sv]
module brs_addr #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [brs_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [brs_pkg::DIM_W-1:0]       cfg_data_i,
  input  logic                            vld_i,
  input  logic                            en_i,
  input  logic                            func_i,
  input  logic [brs_pkg::S_DATA_W-1:0]    tdata_i,
  output logic                            vld_o,
  output brs_pkg::addr_pl_t               pl_o
);

  localparam int unsigned DimMax = (2 ** brs_pkg::DIM_W) - 1;
  localparam int unsigned MaxW   = (MAX_WIDTH > DimMax) ? DimMax : MAX_WIDTH;
  localparam int unsigned MaxH   = (MAX_HEIGHT > DimMax) ? DimMax : MAX_HEIGHT;

  logic [brs_pkg::DIM_W-1:0]     width_q, height_q;
  logic [brs_pkg::DIM_W-1:0]     w_c, h_c;
  logic [brs_pkg::COORD_W-1:0]   wcol, wrow, px, py, row_sel, col_sel;
  logic [brs_pkg::FRAC_W-1:0]    fx, fy;
  logic [brs_pkg::DIM_W-1:0]     px1, py1;
  logic [brs_pkg::WT_W-1:0]      ifx, ify, fxw, fyw;
  logic [2*brs_pkg::WT_W-1:0]    m0, m1, m2, m3;
  logic                          smp;
  logic                          vld_q;
  brs_pkg::addr_pl_t             pl_d, pl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= brs_pkg::DIM_RESET;
      height_q <= brs_pkg::DIM_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        brs_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
        brs_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    w_c = width_q;
    if (width_q < brs_pkg::DIM_MIN) begin
      w_c = brs_pkg::DIM_MIN;
    end else if (width_q > brs_pkg::DIM_W'(MaxW)) begin
      w_c = brs_pkg::DIM_W'(MaxW);
    end
    h_c = height_q;
    if (height_q < brs_pkg::DIM_MIN) begin
      h_c = brs_pkg::DIM_MIN;
    end else if (height_q > brs_pkg::DIM_W'(MaxH)) begin
      h_c = brs_pkg::DIM_W'(MaxH);
    end
  end

  assign wcol = tdata_i[7:0];
  assign wrow = tdata_i[15:8];
  assign px   = tdata_i[63:56];
  assign fx   = tdata_i[55:48];
  assign py   = tdata_i[79:72];
  assign fy   = tdata_i[71:64];
  assign smp  = (func_i == brs_pkg::FUNC_SAMPLE);

  assign row_sel = smp ? py : wrow;
  assign col_sel = smp ? px : wcol;
  assign px1     = brs_pkg::DIM_W'(px) + brs_pkg::DIM_W'(1);
  assign py1     = brs_pkg::DIM_W'(py) + brs_pkg::DIM_W'(1);

  assign fxw = brs_pkg::WT_W'(fx);
  assign fyw = brs_pkg::WT_W'(fy);
  assign ifx = brs_pkg::FULL_WT - fxw;
  assign ify = brs_pkg::FULL_WT - fyw;
  assign m0  = ifx * ify;
  assign m1  = fxw * ify;
  assign m2  = ifx * fyw;
  assign m3  = fxw * fyw;

  always_comb begin
    pl_d.smp   = smp;
    pl_d.oor   = smp && ((px1 >= w_c) || (py1 >= h_c));
    pl_d.wr    = !smp && (brs_pkg::DIM_W'(wcol) < w_c) && (brs_pkg::DIM_W'(wrow) < h_c);
    pl_d.a0    = brs_pkg::LIN_W'(row_sel) * brs_pkg::LIN_W'(w_c)
                 + brs_pkg::LIN_W'(col_sel);
    pl_d.w     = w_c;
    pl_d.pix   = tdata_i[47:16];
    pl_d.wt[0] = m0[brs_pkg::FRAC_W +: brs_pkg::WT_W];
    pl_d.wt[1] = m1[brs_pkg::FRAC_W +: brs_pkg::WT_W];
    pl_d.wt[2] = m2[brs_pkg::FRAC_W +: brs_pkg::WT_W];
    pl_d.wt[3] = m3[brs_pkg::FRAC_W +: brs_pkg::WT_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pl_q <= pl_d;
    end
  end

  assign vld_o = vld_q;
  assign pl_o  = pl_q;

endmodule

[src/brs_store.sv]
module brs_store #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              vld_i,
  input  logic              en_i,
  input  brs_pkg::addr_pl_t pl_i,
  output logic              vld_o,
  output brs_pkg::tap_pl_t  pl_o
);

  localparam int unsigned Depth     = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AddrW     = $clog2(Depth);
  localparam int unsigned BankW     = AddrW - 1;
  localparam int unsigned BankDepth = (Depth + 1) / 2;

  // Two banks split on the low address bit; each has two read ports,
  // one per row of the 2x2 neighborhood.
  logic [brs_pkg::PIX_W-1:0] mem_even [BankDepth];
  logic [brs_pkg::PIX_W-1:0] mem_odd  [BankDepth];

  logic [brs_pkg::LIN_W-1:0] a1;
  logic [brs_pkg::LIN_W:0]   a0p, a1p;
  logic [BankW-1:0]          e0, e1, o0, o1;
  logic                      wr_even, wr_odd;

  logic [brs_pkg::PIX_W-1:0] even0_q, even1_q, odd0_q, odd1_q;
  logic                      par0_q, par1_q, oor_q, vld_q;
  brs_pkg::wt_vec_t          wt_q;

  assign a1  = pl_i.a0 + brs_pkg::LIN_W'(pl_i.w);
  assign a0p = {1'b0, pl_i.a0} + (brs_pkg::LIN_W + 1)'(1);
  assign a1p = {1'b0, a1} + (brs_pkg::LIN_W + 1)'(1);
  assign e0  = BankW'(a0p[brs_pkg::LIN_W:1]);
  assign e1  = BankW'(a1p[brs_pkg::LIN_W:1]);
  assign o0  = BankW'(pl_i.a0[brs_pkg::LIN_W-1:1]);
  assign o1  = BankW'(a1[brs_pkg::LIN_W-1:1]);

  assign wr_even = en_i && vld_i && pl_i.wr && !pl_i.a0[0];
  assign wr_odd  = en_i && vld_i && pl_i.wr && pl_i.a0[0];

  always_ff @(posedge clk_i) begin
    if (wr_even) begin
      mem_even[o0] <= pl_i.pix;
    end
    if (en_i) begin
      even0_q <= mem_even[e0];
      even1_q <= mem_even[e1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_odd) begin
      mem_odd[o0] <= pl_i.pix;
    end
    if (en_i) begin
      odd0_q <= mem_odd[o0];
      odd1_q <= mem_odd[o1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      par0_q <= pl_i.a0[0];
      par1_q <= a1[0];
      oor_q  <= pl_i.oor;
      wt_q   <= pl_i.wt;
    end
  end

  // writes end here; only samples travel on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i && pl_i.smp;
    end
  end

  always_comb begin
    pl_o.oor    = oor_q;
    pl_o.wt     = wt_q;
    pl_o.tap[0] = par0_q ? odd0_q  : even0_q;
    pl_o.tap[1] = par0_q ? even0_q : odd0_q;
    pl_o.tap[2] = par1_q ? odd1_q  : even1_q;
    pl_o.tap[3] = par1_q ? even1_q : odd1_q;
  end

  assign vld_o = vld_q;

endmodule

[src/brs_blend.sv]
module brs_blend (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          vld_i,
  input  brs_pkg::pipe_en_t             en_i,
  input  brs_pkg::tap_pl_t              pl_i,
  output logic                          vld_o,
  output logic [brs_pkg::M_DATA_W-1:0]  data_o,
  output logic                          oor_o
);

  logic [brs_pkg::PROD_W-1:0] prod_d [brs_pkg::NUM_CH][brs_pkg::NUM_TAP];
  logic [brs_pkg::PROD_W-1:0] prod_q [brs_pkg::NUM_CH][brs_pkg::NUM_TAP];
  logic [brs_pkg::SUM_W-1:0]  sum    [brs_pkg::NUM_CH];
  logic [brs_pkg::PIX_W-1:0]  pix_d, data_q;
  logic                       oor3_q, oor4_q, vld3_q, vld4_q;

  always_comb begin
    for (int c = 0; c < brs_pkg::NUM_CH; c++) begin
      for (int k = 0; k < brs_pkg::NUM_TAP; k++) begin
        prod_d[c][k] = brs_pkg::PROD_W'(pl_i.tap[k][c*brs_pkg::CH_W +: brs_pkg::CH_W])
                       * brs_pkg::PROD_W'(pl_i.wt[k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      prod_q <= prod_d;
      oor3_q <= pl_i.oor;
    end
  end

  always_comb begin
    for (int c = 0; c < brs_pkg::NUM_CH; c++) begin
      sum[c] = brs_pkg::SUM_W'(prod_q[c][0]) + brs_pkg::SUM_W'(prod_q[c][1])
               + brs_pkg::SUM_W'(prod_q[c][2]) + brs_pkg::SUM_W'(prod_q[c][3]);
      pix_d[c*brs_pkg::CH_W +: brs_pkg::CH_W] = sum[c][brs_pkg::FRAC_W +: brs_pkg::CH_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s4) begin
      data_q <= oor3_q ? '0 : pix_d;
      oor4_q <= oor3_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld3_q <= 1'b0;
      vld4_q <= 1'b0;
    end else begin
      if (en_i.s3) begin
        vld3_q <= vld_i;
      end
      if (en_i.s4) begin
        vld4_q <= vld3_q;
      end
    end
  end

  assign vld_o  = vld4_q;
  assign data_o = data_q;
  assign oor_o  = oor4_q;

endmodule

[src/bilinear_rgba_sampler.sv]
// Bilinear RGBA8 sampler with an on-chip pixel store.
// Input stream: tuser selects a pixel write (0) or a sample (1). A write
// loads one pixel at (col,row); writes outside the image are dropped and
// give no output. A sample at UQ8.8 (x,y) gives one output transfer with
// the interpolated pixel, or zero with out_of_range set when the 2x2
// neighborhood leaves the image.
// Config port: index 0 sets image width, 1 sets height; write only while
// the pipeline is empty.
// Four register stages: address and weights, banked store read, per-channel
// products, sum and output register. Output valid rises once an accepted
// item has passed all four registers in order.
// Throughput is one item per cycle while the receiver does not stall; the
// even/odd banks with two read ports each serve all four neighbors at once.
// Reset clears the pipeline valids and sets a 256x256 image; the pixel
// store is not cleared and holds garbage until written.
// When the receiver stalls, results wait in the output register and empty
// stages upstream keep filling; s_axis_tready drops once all are full.
module bilinear_rgba_sampler #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [brs_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [brs_pkg::DIM_W-1:0]     cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // write_col[7:0], write_row[15:8], write_pixel[47:16],
  // sample_x[63:48], sample_y[79:64]
  input  logic [brs_pkg::S_DATA_W-1:0]  s_axis_tdata,
  // func[0]
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // pixel_out[31:0]
  output logic [brs_pkg::M_DATA_W-1:0]  m_axis_tdata,
  // out_of_range[0]
  output logic                          m_axis_tuser
);

  brs_pkg::pipe_en_t en;
  brs_pkg::addr_pl_t addr_pl;
  brs_pkg::tap_pl_t  tap_pl;
  logic              vld1, vld2, vld3_mirror;

  always_comb begin
    en.s4 = !m_axis_tvalid || m_axis_tready;
    en.s3 = !vld3_mirror || en.s4;
    en.s2 = !vld2 || en.s3;
    en.s1 = !vld1 || en.s2;
  end

  assign s_axis_tready = en.s1;

  brs_addr #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_addr (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .vld_i      (s_axis_tvalid),
    .en_i       (en.s1),
    .func_i     (s_axis_tuser),
    .tdata_i    (s_axis_tdata),
    .vld_o      (vld1),
    .pl_o       (addr_pl)
  );

  brs_store #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (vld1),
    .en_i   (en.s2),
    .pl_i   (addr_pl),
    .vld_o  (vld2),
    .pl_o   (tap_pl)
  );

  // stage 3 valid mirrored here for the ready chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld3_mirror <= 1'b0;
    end else if (en.s3) begin
      vld3_mirror <= vld2;
    end
  end

  brs_blend u_blend (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (vld2),
    .en_i   (en),
    .pl_i   (tap_pl),
    .vld_o  (m_axis_tvalid),
    .data_o (m_axis_tdata),
    .oor_o  (m_axis_tuser)
  );

endmodule

[src/brs_checker.sv]
module brs_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          s_axis_tuser,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [brs_pkg::M_DATA_W-1:0]  m_axis_tdata,
  input logic                          m_axis_tuser
);

`include "bilinear_rgba_sampler_assert.svh"

  logic                          out_stall, out_oor;
  logic [brs_pkg::M_DATA_W:0]    out_word;
  logic [2:0]                    pend_d, pend_q;

  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign out_oor   = m_axis_tvalid && m_axis_tuser;
  assign out_word  = {m_axis_tuser, m_axis_tdata};

  // samples accepted and not yet transferred out
  always_comb begin
    pend_d = pend_q;
    if (s_axis_tvalid && s_axis_tready && (s_axis_tuser == brs_pkg::FUNC_SAMPLE)) begin
      pend_d = pend_d + 3'd1;
    end
    if (m_axis_tvalid && m_axis_tready) begin
      pend_d = pend_d - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 3'd0;
    end else begin
      pend_q <= pend_d;
    end
  end

  `BRS_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable(out_word), "output moved")
  `BRS_ASSERT_NOW(a_oor_zero, out_oor, m_axis_tdata == '0, "oor pixel nonzero")
  `BRS_ASSERT_NOW(a_ready_free, !out_stall, s_axis_tready, "input stalled with a free output")
  `BRS_ASSERT_NOW(a_no_phantom, m_axis_tvalid, pend_q != 3'd0, "result with no sample")

endmodule

bind bilinear_rgba_sampler brs_checker u_brs_checker (.*);

[sim/tb_bilinear_rgba_sampler.sv]
`timescale 1ns / 100ps

module tb_bilinear_rgba_sampler;

  localparam int unsigned IMG_MAX         = 256;
  localparam int unsigned DRAIN_CYCLES    = 8;
  localparam int unsigned STALL_LIMIT     = 2000;
  localparam int unsigned RANDOM_PHASES   = 12;
  localparam int unsigned ITEMS_PER_PHASE = 125;

  typedef struct packed {
    logic [brs_pkg::PIX_W-1:0] pixel;
    logic                      oor;
  } sample_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [brs_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [brs_pkg::DIM_W-1:0]      cfg_data_i;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [brs_pkg::S_DATA_W-1:0]   s_axis_tdata;
  logic                           s_axis_tuser;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [brs_pkg::M_DATA_W-1:0]   m_axis_tdata;
  logic                           m_axis_tuser;

  logic [brs_pkg::PIX_W-1:0] pixel_mem [IMG_MAX*IMG_MAX];
  bit                        written   [IMG_MAX*IMG_MAX];
  logic [brs_pkg::DIM_W-1:0] width_reg  = brs_pkg::DIM_RESET;
  logic [brs_pkg::DIM_W-1:0] height_reg = brs_pkg::DIM_RESET;
  sample_t          expected_samples [$];
  int unsigned      mismatches   = 0;
  int unsigned      quiet_cycles = 0;
  int unsigned      items_sent   = 0;
  int unsigned      src_idle_pct  = 29;
  int unsigned      sink_stall_pct = 66;

  bilinear_rgba_sampler dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #10 clk_i = ~clk_i;

  function automatic int unsigned used_dim(logic [brs_pkg::DIM_W-1:0] raw);
    if (raw < brs_pkg::DIM_MIN) return 32'(brs_pkg::DIM_MIN);
    if (raw > IMG_MAX) return IMG_MAX;
    return 32'(raw);
  endfunction

  function automatic sample_t interpolate(logic [15:0] x, logic [15:0] y);
    sample_t                   r;
    int unsigned               w, h, px, py, fx, fy, acc;
    int unsigned               wt [4];
    logic [brs_pkg::PIX_W-1:0] tap [4];
    w  = used_dim(width_reg);
    h  = used_dim(height_reg);
    px = 32'(x[15:8]);
    py = 32'(y[15:8]);
    fx = 32'(x[7:0]);
    fy = 32'(y[7:0]);
    r.pixel = '0;
    r.oor   = 1'b1;
    if (px + 1 >= w || py + 1 >= h) return r;
    r.oor  = 1'b0;
    tap[0] = pixel_mem[py*w + px];
    tap[1] = pixel_mem[py*w + px + 1];
    tap[2] = pixel_mem[(py+1)*w + px];
    tap[3] = pixel_mem[(py+1)*w + px + 1];
    wt[0]  = ((256 - fx) * (256 - fy)) >> 8;
    wt[1]  = (fx * (256 - fy)) >> 8;
    wt[2]  = ((256 - fx) * fy) >> 8;
    wt[3]  = (fx * fy) >> 8;
    for (int ch = 0; ch < brs_pkg::NUM_CH; ch++) begin
      acc = 0;
      for (int k = 0; k < brs_pkg::NUM_TAP; k++) begin
        acc += 32'(tap[k][ch*brs_pkg::CH_W +: brs_pkg::CH_W]) * wt[k];
      end
      r.pixel[ch*brs_pkg::CH_W +: brs_pkg::CH_W] = 8'(acc >> 8);
    end
    return r;
  endfunction

  // transfer checker
  always @(posedge clk_i) begin
    sample_t exp_s;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_samples.size() == 0) begin
        $error("result with none pending: pixel_out %h out_of_range %b",
               m_axis_tdata, m_axis_tuser);
        mismatches++;
      end else begin
        exp_s = expected_samples.pop_front();
        if (m_axis_tdata !== exp_s.pixel) begin
          $error("pixel_out: expected %h, got %h", exp_s.pixel, m_axis_tdata);
          mismatches++;
        end
        if (m_axis_tuser !== exp_s.oor) begin
          $error("out_of_range: expected %b, got %b", exp_s.oor, m_axis_tuser);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic send_item(logic func, logic [7:0] col, logic [7:0] row,
                           logic [31:0] pix, logic [15:0] x, logic [15:0] y);
    int unsigned w, h, addr;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= {y, x, pix, row, col};
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    w = used_dim(width_reg);
    h = used_dim(height_reg);
    if (func == brs_pkg::FUNC_SAMPLE) begin
      expected_samples.push_back(interpolate(x, y));
    end else if (col < w && row < h) begin
      addr            = row * w + col;
      pixel_mem[addr] = pix;
      written[addr]   = 1'b1;
    end
  endtask

  task automatic write_pixel(logic [7:0] col, logic [7:0] row, logic [31:0] pix);
    send_item(brs_pkg::FUNC_WRITE, col, row, pix, 16'($urandom), 16'($urandom));
  endtask

  task automatic sample_at(logic [15:0] x, logic [15:0] y);
    send_item(brs_pkg::FUNC_SAMPLE, 8'($urandom), 8'($urandom), $urandom, x, y);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_reg(logic [brs_pkg::CFG_IDX_W-1:0] idx,
                         logic [brs_pkg::DIM_W-1:0] value);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == brs_pkg::REG_IMAGE_WIDTH) width_reg = value;
    else height_reg = value;
  endtask

  // in-image sample; missing neighbors are written first
  task automatic sample_inside();
    int unsigned w, h, px, py;
    w  = used_dim(width_reg);
    h  = used_dim(height_reg);
    px = $urandom_range(0, w - 2);
    py = $urandom_range(0, h - 2);
    for (int dy = 0; dy < 2; dy++) begin
      for (int dx = 0; dx < 2; dx++) begin
        if (!written[(py+dy)*w + px + dx]) begin
          write_pixel(8'(px + dx), 8'(py + dy), $urandom);
        end
      end
    end
    sample_at({px[7:0], 8'($urandom)}, {py[7:0], 8'($urandom)});
  endtask

  task automatic sample_outside();
    int unsigned w, h;
    logic [7:0]  p;
    w = used_dim(width_reg);
    h = used_dim(height_reg);
    if ($urandom_range(0, 1)) begin
      p = 8'($urandom_range(w - 1, 255));
      sample_at({p, 8'($urandom)}, 16'($urandom));
    end else begin
      p = 8'($urandom_range(h - 1, 255));
      sample_at(16'($urandom), {p, 8'($urandom)});
    end
  endtask

  task automatic write_random(bit outside);
    int unsigned w, h;
    logic [7:0]  col, row;
    w   = used_dim(width_reg);
    h   = used_dim(height_reg);
    col = 8'($urandom_range(0, w - 1));
    row = 8'($urandom_range(0, h - 1));
    if (outside) begin
      if (w < IMG_MAX && (h == IMG_MAX || $urandom_range(0, 1))) begin
        col = 8'($urandom_range(w, 255));
        row = 8'($urandom);
      end else if (h < IMG_MAX) begin
        row = 8'($urandom_range(h, 255));
        col = 8'($urandom);
      end
    end
    write_pixel(col, row, $urandom);
  endtask

  function automatic logic [brs_pkg::DIM_W-1:0] random_dim();
    case ($urandom_range(0, 9))
      0, 1: begin
        case ($urandom_range(0, 6))
          0: return 9'd0;
          1: return 9'd1;
          2: return 9'd2;
          3: return 9'd255;
          4: return 9'd256;
          5: return 9'd257;
          default: return 9'd511;
        endcase
      end
      2, 3, 4, 5, 6: return 9'($urandom_range(2, 12));
      default: return 9'($urandom_range(0, 511));
    endcase
  endfunction

  task automatic test_default_size();
    write_pixel(254, 254, 32'hFFFF_FFFF);
    write_pixel(255, 254, 32'h0000_0000);
    write_pixel(254, 255, 32'h00FF_00FF);
    write_pixel(255, 255, 32'h1234_5678);
    sample_at(16'hFE00, 16'hFE00);
    sample_at(16'hFEFF, 16'hFEFF);
    sample_at(16'hFE80, 16'hFE01);
    sample_at(16'hFF00, 16'h0000);
    sample_at(16'hFFFF, 16'hFFFF);
    sample_at(16'h0000, 16'hFF80);
  endtask

  // register values below the minimum clamp to a 2x2 image
  task automatic test_clamped_small_image();
    set_reg(brs_pkg::REG_IMAGE_WIDTH, 9'd0);
    set_reg(brs_pkg::REG_IMAGE_HEIGHT, 9'd1);
    write_pixel(0, 0, 32'hFF00_FF00);
    write_pixel(1, 0, 32'h80FF_0001);
    write_pixel(0, 1, 32'h0102_0304);
    write_pixel(1, 1, 32'hFFFF_FFFF);
    write_pixel(2, 0, 32'hDEAD_BEEF);
    write_pixel(0, 2, 32'hDEAD_BEEF);
    write_pixel(255, 255, 32'hDEAD_BEEF);
    sample_at(16'h0080, 16'h0080);
    sample_at(16'h00FF, 16'h0000);
    sample_at(16'h0100, 16'h0000);
    sample_at(16'h0000, 16'h0100);
  endtask

  task automatic test_clamped_large_image();
    set_reg(brs_pkg::REG_IMAGE_WIDTH, 9'd511);
    set_reg(brs_pkg::REG_IMAGE_HEIGHT, 9'd257);
    sample_at(16'hFE40, 16'hFEC0);
  endtask

  // pixels keep their linear address across a stride change
  task automatic test_stride_change();
    set_reg(brs_pkg::REG_IMAGE_WIDTH, 9'd3);
    set_reg(brs_pkg::REG_IMAGE_HEIGHT, 9'd2);
    write_pixel(1, 1, 32'h7F3C_A055);
    sample_at(16'h0040, 16'h00C0);
  endtask

  task automatic test_random_traffic();
    int unsigned phase_end;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase < RANDOM_PHASES / 3) begin
        src_idle_pct   = 29;
        sink_stall_pct = 66;
      end else if (phase < 2 * RANDOM_PHASES / 3) begin
        src_idle_pct   = 66;
        sink_stall_pct = 29;
      end else begin
        src_idle_pct   = 0;
        sink_stall_pct = 0;
      end
      set_reg(brs_pkg::REG_IMAGE_WIDTH, random_dim());
      set_reg(brs_pkg::REG_IMAGE_HEIGHT, random_dim());
      phase_end = items_sent + ITEMS_PER_PHASE;
      while (items_sent < phase_end) begin
        case ($urandom_range(0, 9))
          0, 1, 2: write_random(1'b0);
          3: write_random(1'b1);
          4: sample_outside();
          default: sample_inside();
        endcase
      end
    end
  endtask

  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= brs_pkg::REG_IMAGE_WIDTH;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= brs_pkg::FUNC_WRITE;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_size();
    test_clamped_small_image();
    test_clamped_large_image();
    test_stride_change();
    test_random_traffic();

    drain();
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
